/* sv/gisf_pkg.sv */
// ----------------------------------------------------------------------------
// gisf_pkg
// Shared widths, control codes and the microcode program of the gyro
// interleave smoothing filter.
// ----------------------------------------------------------------------------
package gisf_pkg;

  // field and datapath widths
  localparam int Axes     = 3;
  localparam int AxisW    = 2;
  localparam int SampleW  = 15;
  localparam int RateW    = 16;
  localparam int FactorW  = 8;
  localparam int AccW     = 25;
  localparam int StepW    = 4;
  localparam int CfgIdxW  = 2;
  localparam int InDataW  = 96;
  localparam int OutDataW = 48;
  localparam int Prod3W   = 32;

  // reciprocal of three for the interleave average, exact below 2^16
  localparam logic [RateW-1:0] RecipThree      = 16'hAAAB;
  localparam int               RecipThreeShift = 17;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_PAIR,
    OP_ABS3,
    OP_MUL3,
    OP_RATE,
    OP_MUL,
    OP_DIVF,
    OP_SMOOTH,
    OP_NEXT,
    OP_EMIT
  } op_e;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_DIV_BUSY,
    C_NO_SMOOTH,
    C_ZERO_F,
    C_MORE_AXES,
    C_OUT_FULL
  } cond_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SMOOTH_EN,
    REG_FACTOR_ROLL,
    REG_FACTOR_PITCH,
    REG_FACTOR_YAW
  } cfg_reg_e;

  // program step addresses
  localparam logic [StepW-1:0] STEP_IDLE   = 4'd0;
  localparam logic [StepW-1:0] STEP_PAIR   = 4'd1;
  localparam logic [StepW-1:0] STEP_ABS3   = 4'd2;
  localparam logic [StepW-1:0] STEP_MUL3   = 4'd3;
  localparam logic [StepW-1:0] STEP_RATE   = 4'd4;
  localparam logic [StepW-1:0] STEP_MUL    = 4'd5;
  localparam logic [StepW-1:0] STEP_DIVF   = 4'd6;
  localparam logic [StepW-1:0] STEP_WAITF  = 4'd7;
  localparam logic [StepW-1:0] STEP_SMOOTH = 4'd8;
  localparam logic [StepW-1:0] STEP_NEXT   = 4'd9;
  localparam logic [StepW-1:0] STEP_HOLD   = 4'd10;
  localparam logic [StepW-1:0] STEP_EMIT   = 4'd11;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [StepW-1:0] target;
  } ctrl_word_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic in_full;
    logic div_busy;
    logic no_smooth;
    logic zero_f;
    logic more_axes;
    logic out_full;
  } status_t;

  // microcode program
  function automatic ctrl_word_t program_word(logic [StepW-1:0] step);
    ctrl_word_t w;
    case (step)
      STEP_IDLE:   w = '{OP_NOP,    C_NO_INPUT,  STEP_IDLE};
      STEP_PAIR:   w = '{OP_PAIR,   C_NEXT,      STEP_IDLE};
      STEP_ABS3:   w = '{OP_ABS3,   C_NEXT,      STEP_IDLE};
      STEP_MUL3:   w = '{OP_MUL3,   C_NEXT,      STEP_IDLE};
      STEP_RATE:   w = '{OP_RATE,   C_NO_SMOOTH, STEP_NEXT};
      STEP_MUL:    w = '{OP_MUL,    C_ZERO_F,    STEP_SMOOTH};
      STEP_DIVF:   w = '{OP_DIVF,   C_NEXT,      STEP_IDLE};
      STEP_WAITF:  w = '{OP_NOP,    C_DIV_BUSY,  STEP_WAITF};
      STEP_SMOOTH: w = '{OP_SMOOTH, C_NEXT,      STEP_IDLE};
      STEP_NEXT:   w = '{OP_NEXT,   C_MORE_AXES, STEP_PAIR};
      STEP_HOLD:   w = '{OP_NOP,    C_OUT_FULL,  STEP_HOLD};
      STEP_EMIT:   w = '{OP_EMIT,   C_ALWAYS,    STEP_IDLE};
      default:     w = '{OP_NOP,    C_ALWAYS,    STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* sv/gisf_seq.sv */
// ----------------------------------------------------------------------------
// gisf_seq
// Step counter of the microcode program with conditional jumps.
// ----------------------------------------------------------------------------
module gisf_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gisf_pkg::status_t status_i,
  output gisf_pkg::op_e     op_o
);

  logic [gisf_pkg::StepW-1:0] step_q, step_d;
  gisf_pkg::ctrl_word_t       word;
  logic                       jump;

  // fetch the control word of the current step
  assign word = gisf_pkg::program_word(step_q);
  assign op_o = word.op;

  // jump condition
  always_comb begin
    case (word.cond)
      gisf_pkg::C_NEXT:      jump = 1'b0;
      gisf_pkg::C_ALWAYS:    jump = 1'b1;
      gisf_pkg::C_NO_INPUT:  jump = !status_i.in_full;
      gisf_pkg::C_DIV_BUSY:  jump = status_i.div_busy;
      gisf_pkg::C_NO_SMOOTH: jump = status_i.no_smooth;
      gisf_pkg::C_ZERO_F:    jump = status_i.zero_f;
      gisf_pkg::C_MORE_AXES: jump = status_i.more_axes;
      gisf_pkg::C_OUT_FULL:  jump = status_i.out_full;
      default:               jump = 1'b0;
    endcase
  end

  assign step_d = jump ? word.target : step_q + 1'b1;

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= gisf_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

/* sv/gisf_div.sv */
// ----------------------------------------------------------------------------
// gisf_div
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module gisf_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [gisf_pkg::AccW-1:0]    dividend_i,
  input  logic [gisf_pkg::FactorW-1:0]        divisor_i,
  output logic                                busy_o,
  output logic [gisf_pkg::RateW-1:0]          quotient_o
);

  localparam int CntW = $clog2(gisf_pkg::AccW);

  logic                          busy_q;
  logic [CntW-1:0]               cnt_q;
  logic                          neg_q;
  logic [gisf_pkg::FactorW-1:0]  rem_q;
  logic [gisf_pkg::FactorW-1:0]  dvs_q;
  logic [gisf_pkg::AccW-1:0]     quo_q;
  logic [gisf_pkg::FactorW:0]    shifted;
  logic [gisf_pkg::FactorW:0]    diff;
  logic                          ge;
  logic [gisf_pkg::AccW-1:0]     signed_quo;

  // one restoring step
  assign shifted = {rem_q, quo_q[gisf_pkg::AccW-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  assign signed_quo = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quotient_o = signed_quo[gisf_pkg::RateW-1:0];
  assign busy_o     = busy_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(gisf_pkg::AccW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // magnitude and remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[gisf_pkg::AccW-1];
      quo_q <= dividend_i[gisf_pkg::AccW-1] ? (~dividend_i + 1'b1) : dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[gisf_pkg::FactorW-1:0] : shifted[gisf_pkg::FactorW-1:0];
      quo_q <= {quo_q[gisf_pkg::AccW-2:0], ge};
    end
  end

endmodule

/* sv/gyro_interleave_smoothing_filter.sv */
// ----------------------------------------------------------------------------
// gyro_interleave_smoothing_filter
// Averages interleaved gyro reading pairs per axis and applies an optional
// first-order smoothing stage, under control of a small microcode program.
// ----------------------------------------------------------------------------
// Flow: one item at a time; smoothing makes an axis wait on the shared serial
//   divider, and a zero factor skips the divider. The next item is taken while
//   a result waits; the emit step of the next item holds until the waiting
//   result is taken.
// Reset: asynchronous, active low; clears the configuration registers, the
//   handshake flags, the axis index, halves and smoothed values.
module gyro_interleave_smoothing_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gisf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [gisf_pkg::FactorW-1:0]      cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // first_roll, first_pitch, first_yaw, second_roll, second_pitch,
  // second_yaw (15 bits each), zero pad
  input  logic [gisf_pkg::InDataW-1:0]      s_axis_tdata,
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // rate_roll, rate_pitch, rate_yaw (16 bits each)
  output logic [gisf_pkg::OutDataW-1:0]     m_axis_tdata
);

  localparam int SamplesW = 2 * gisf_pkg::Axes * gisf_pkg::SampleW;

  gisf_pkg::op_e     op;
  gisf_pkg::status_t status;

  logic                               smooth_en_q;
  logic [gisf_pkg::FactorW-1:0]       factor_q [gisf_pkg::Axes];
  logic                               in_full_q;
  logic [SamplesW-1:0]                in_q;
  logic                               out_full_q;
  logic [gisf_pkg::OutDataW-1:0]      out_q;
  logic [gisf_pkg::AxisW-1:0]         axis_q;
  logic signed [gisf_pkg::RateW-1:0]  pair_q;
  logic signed [gisf_pkg::AccW-1:0]   acc_q;
  logic                               neg3_q;
  logic [gisf_pkg::RateW-1:0]         mag3_q;
  logic [gisf_pkg::Prod3W-1:0]        prod3_q;
  logic signed [gisf_pkg::RateW-1:0]  rate_q   [gisf_pkg::Axes];
  logic signed [gisf_pkg::RateW-1:0]  half_q   [gisf_pkg::Axes];
  logic signed [gisf_pkg::RateW-1:0]  smooth_q [gisf_pkg::Axes];

  logic signed [gisf_pkg::SampleW-1:0] first_s, second_s;
  logic signed [gisf_pkg::RateW-1:0]   pair;
  logic signed [gisf_pkg::RateW:0]     half_sum;
  logic signed [gisf_pkg::RateW-1:0]   half_val;
  logic [gisf_pkg::RateW-1:0]          quo3;
  logic signed [gisf_pkg::RateW-1:0]   rate3;
  logic [gisf_pkg::FactorW-1:0]        factor;
  logic signed [gisf_pkg::FactorW:0]   factor_m1;
  logic signed [gisf_pkg::AccW-1:0]    product;
  logic signed [gisf_pkg::RateW-1:0]   smooth_val;
  logic                                div_start;
  logic                                div_busy;
  logic [gisf_pkg::RateW-1:0]          div_quo;
  logic                                in_xfer, out_xfer;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !in_full_q;
  assign m_axis_tvalid = out_full_q;
  assign m_axis_tdata  = out_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;

  // per-axis operands
  assign first_s   = in_q[axis_q*gisf_pkg::SampleW +: gisf_pkg::SampleW];
  assign second_s  = in_q[(axis_q + gisf_pkg::AxisW'(gisf_pkg::Axes))*gisf_pkg::SampleW
                          +: gisf_pkg::SampleW];
  assign pair      = gisf_pkg::RateW'(first_s) + gisf_pkg::RateW'(second_s);
  assign half_sum  = {pair_q[gisf_pkg::RateW-1], pair_q}
                     + (gisf_pkg::RateW+1)'(pair_q[gisf_pkg::RateW-1]);
  assign half_val  = half_sum[gisf_pkg::RateW:1];
  assign factor    = factor_q[axis_q];
  assign factor_m1 = {1'b0, factor - 1'b1};
  assign product   = gisf_pkg::AccW'(smooth_q[axis_q]) * gisf_pkg::AccW'(factor_m1);
  assign smooth_val = (factor == '0) ? rate_q[axis_q] : div_quo;

  // divide by three through the reciprocal, sign restored afterwards
  assign quo3  = gisf_pkg::RateW'(prod3_q >> gisf_pkg::RecipThreeShift);
  assign rate3 = neg3_q ? (~quo3 + 1'b1) : quo3;

  // divider hookup
  assign div_start = (op == gisf_pkg::OP_DIVF);

  // status for the sequencer
  assign status.in_full   = in_full_q;
  assign status.div_busy  = div_busy;
  assign status.no_smooth = !smooth_en_q;
  assign status.zero_f    = (factor == '0);
  assign status.more_axes = (axis_q != gisf_pkg::AxisW'(gisf_pkg::Axes - 1));
  assign status.out_full  = out_full_q;

  gisf_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .op_o     (op)
  );

  gisf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (factor),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // configuration, handshakes and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_en_q <= 1'b0;
      in_full_q   <= 1'b0;
      out_full_q  <= 1'b0;
      axis_q      <= '0;
      for (int i = 0; i < gisf_pkg::Axes; i++) begin
        factor_q[i] <= '0;
        half_q[i]   <= '0;
        smooth_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          gisf_pkg::REG_SMOOTH_EN:    smooth_en_q <= cfg_data_i[0];
          gisf_pkg::REG_FACTOR_ROLL:  factor_q[0] <= cfg_data_i;
          gisf_pkg::REG_FACTOR_PITCH: factor_q[1] <= cfg_data_i;
          gisf_pkg::REG_FACTOR_YAW:   factor_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_xfer) begin
        in_full_q <= 1'b1;
      end
      if (out_xfer) begin
        out_full_q <= 1'b0;
      end
      case (op)
        gisf_pkg::OP_RATE: begin
          half_q[axis_q] <= half_val;
        end
        gisf_pkg::OP_SMOOTH: begin
          smooth_q[axis_q] <= smooth_val;
        end
        gisf_pkg::OP_NEXT: begin
          axis_q <= status.more_axes ? axis_q + 1'b1 : '0;
        end
        gisf_pkg::OP_EMIT: begin
          in_full_q  <= 1'b0;
          out_full_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= s_axis_tdata[SamplesW-1:0];
    end
    case (op)
      gisf_pkg::OP_PAIR: begin
        pair_q <= pair;
        acc_q  <= gisf_pkg::AccW'(pair) + gisf_pkg::AccW'(half_q[axis_q]);
      end
      gisf_pkg::OP_ABS3: begin
        neg3_q <= acc_q[gisf_pkg::AccW-1];
        mag3_q <= gisf_pkg::RateW'(acc_q[gisf_pkg::AccW-1] ? -acc_q : acc_q);
      end
      gisf_pkg::OP_MUL3: begin
        prod3_q <= gisf_pkg::Prod3W'(mag3_q) * gisf_pkg::Prod3W'(gisf_pkg::RecipThree);
      end
      gisf_pkg::OP_RATE: begin
        rate_q[axis_q] <= rate3;
      end
      gisf_pkg::OP_MUL: begin
        acc_q <= product + gisf_pkg::AccW'(rate_q[axis_q]) + gisf_pkg::AccW'(1);
      end
      gisf_pkg::OP_SMOOTH: begin
        rate_q[axis_q] <= smooth_val;
      end
      gisf_pkg::OP_EMIT: begin
        out_q <= {rate_q[2], rate_q[1], rate_q[0]};
      end
      default: ;
    endcase
  end

endmodule
